FILE: rtl/bebac_pkg.sv
// bebac_pkg: shared types and constants for the band epoch budget admission core.
// Holds the beat structs, sequencer states, adder ops and register indices.
// No dependencies; every other file imports it.
package bebac_pkg;

   // Sizing
   localparam int BAND_SLOTS = 8;
   localparam int TIME_BITS = 64;
   localparam int BAND_W    = (BAND_SLOTS > 1) ? $clog2(BAND_SLOTS) : 1;
   localparam int LEN_W     = 16;
   localparam int PRIO_W    = 8;
   localparam int NOW_W     = 64;
   localparam int BUDGET_W  = 32;
   localparam int QUANT_W   = 32;
   localparam int UNIT_W    = 16;
   localparam int MULT_W    = 16;
   localparam int MULTS_W   = 64;
   localparam int COUNT_W   = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 64;

   // Register indices
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MULTS_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MULTS_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_COUNT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DOWNGRADE  = 3'd5;

   // Register reset values
   localparam logic [QUANT_W-1:0] QUANTUM_RST    = 32'd100000;
   localparam logic [UNIT_W-1:0]  UNIT_RST       = 16'd128;
   localparam logic [MULTS_W-1:0] MULTS_LOW_RST  = {16'd1000, 16'd0, 16'd0, 16'd10000};
   localparam logic [MULTS_W-1:0] MULTS_HIGH_RST = {16'd1, 16'd5, 16'd10, 16'd100};
   localparam logic [COUNT_W-1:0] BAND_COUNT_RST = 4'd8;

   // Request beat
   typedef struct packed {
      logic [LEN_W-1:0]  packet_length;
      logic [PRIO_W-1:0] priority_req;
      logic [NOW_W-1:0]  now_cycles;
   } req_type;

   // Response beat
   typedef struct packed {
      logic                admitted;
      logic [2:0]          granted_band;
      logic [BUDGET_W-1:0] budget_left;
   } rsp_type;

   // Band store write controls
   typedef struct packed {
      logic                 epoch_we;
      logic [TIME_BITS-1:0] epoch_val;
      logic                 bytes_we;
      logic [BUDGET_W-1:0]  bytes_val;
   } store_wr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EPOCH,
      ST_REFILL,
      ST_FIT,
      ST_DONE
   } state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

endpackage

FILE: rtl/band_epoch_budget_admission_core.sv
// band_epoch_budget_admission_core: per-band fixed-window byte budget admission.
// Top level: config registers, sequencer, limit multiplier; uses bebac_alu,
// bebac_store and bebac_pkg.
//
//   channel | ports                          | direction | handshake
//   --------+--------------------------------+-----------+------------------------
//   request | req_valid req_stall req_data   | in        | valid & !stall
//   result  | rsp_valid rsp_stall rsp_data   | out       | valid & !stall
//   config  | csr_valid csr_ready csr_index  | in        | valid & ready
//           | csr_wdata                      |           |
//
// Each band tried uses the shared adder for the epoch compare, the epoch end
// sum, then the fit and deduct; a packet tries from 1 to 6 bands (longest
// chain 7, 6, 5, 4, 3, 0). req_stall is high from acceptance until the result
// is in the output register, which holds while rsp_stall is high.
// Synchronous reset clears all band state at once; csr_ready is always high.
module band_epoch_budget_admission_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  bebac_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output bebac_pkg::rsp_type                rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bebac_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bebac_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   import bebac_pkg::*;

   // configuration registers
   logic [QUANT_W-1:0] quantum_ff;
   logic [UNIT_W-1:0]  unit_ff;
   logic [MULTS_W-1:0] mults_low_ff;
   logic [MULTS_W-1:0] mults_high_ff;
   logic [COUNT_W-1:0] band_count_ff;
   logic               downgrade_ff;

   // sequencer state
   state_type             state_ff, state_in;
   req_type               item_ff, item_in;
   logic [BAND_W-1:0]     band_ff, band_in;
   logic                  ge_ff, ge_in;
   logic [BUDGET_W-1:0]   limit_ff, limit_in;
   logic [BUDGET_W-1:0]   budget_ff, budget_in;
   rsp_type               pend_ff, pend_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // shared unit and store
   alu_op_type            alu_op;
   logic [TIME_BITS-1:0]  alu_a, alu_b, alu_sum;
   logic                  alu_carry;
   store_wr_type          st_wr;
   logic [BUDGET_W-1:0]   rd_bytes;
   logic [TIME_BITS-1:0]  rd_epoch;

   // derived
   logic [4:0]            bands_eff;
   logic [PRIO_W-1:0]     start_prio;
   logic [7:0][MULT_W-1:0] mult_vec;
   logic [MULT_W-1:0]     mult;
   logic [BAND_W-1:0]     next_band;
   logic [TIME_BITS-1:0]  now_t;

   assign csr_ready = 1'b1;

   // config writes; unknown indices are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff    <= QUANTUM_RST;
         unit_ff       <= UNIT_RST;
         mults_low_ff  <= MULTS_LOW_RST;
         mults_high_ff <= MULTS_HIGH_RST;
         band_count_ff <= BAND_COUNT_RST;
         downgrade_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_QUANTUM:    quantum_ff    <= csr_wdata[QUANT_W-1:0];
            CSR_UNIT:       unit_ff       <= csr_wdata[UNIT_W-1:0];
            CSR_MULTS_LOW:  mults_low_ff  <= csr_wdata;
            CSR_MULTS_HIGH: mults_high_ff <= csr_wdata;
            CSR_BAND_COUNT: band_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_DOWNGRADE:  downgrade_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // clamp the requested band to the bands in use
   always_comb begin
      if (band_count_ff == '0) begin
         bands_eff = 5'd1;
      end else if (5'(band_count_ff) > 5'(BAND_SLOTS)) begin
         bands_eff = 5'(BAND_SLOTS);
      end else begin
         bands_eff = 5'(band_count_ff);
      end
      if (req_data.priority_req >= PRIO_W'(bands_eff)) begin
         start_prio = PRIO_W'(bands_eff - 5'd1);
      end else begin
         start_prio = req_data.priority_req;
      end
   end

   // multiplier of the current band; bands 8 and up have none
   assign mult_vec = {mults_high_ff, mults_low_ff};
   always_comb begin
      if (32'(band_ff) < 32'd8) begin
         mult = mult_vec[3'(band_ff)];
      end else begin
         mult = '0;
      end
   end

   // downgrade order: band 3 drops to band 0, others step down by one
   assign next_band = (32'(band_ff) == 32'd3) ? '0 : band_ff - BAND_W'(1);
   assign now_t     = item_ff.now_cycles[TIME_BITS-1:0];

   bebac_alu u_alu (
      .op    (alu_op),
      .a     (alu_a),
      .b     (alu_b),
      .sum   (alu_sum),
      .carry (alu_carry)
   );

   bebac_store u_store (
      .clock    (clock),
      .reset    (reset),
      .band     (band_ff),
      .wr       (st_wr),
      .rd_bytes (rd_bytes),
      .rd_epoch (rd_epoch)
   );

   // sequencer: next state, adder operands and store writes
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      band_in      = band_ff;
      ge_in        = ge_ff;
      limit_in     = limit_ff;
      budget_in    = budget_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      alu_op       = ALU_SUB;
      alu_a        = '0;
      alu_b        = '0;
      st_wr        = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               band_in  = BAND_W'(start_prio);
               state_in = ST_EPOCH;
            end
         end
         // epoch over when now >= epoch end; limit formed alongside
         ST_EPOCH: begin
            alu_op   = ALU_SUB;
            alu_a    = now_t;
            alu_b    = rd_epoch;
            ge_in    = alu_carry;
            limit_in = BUDGET_W'(mult) * BUDGET_W'(unit_ff);
            state_in = ST_REFILL;
         end
         // refill and move the epoch end, or load the budget as it stands
         ST_REFILL: begin
            alu_op = ALU_ADD;
            alu_a  = now_t;
            alu_b  = TIME_BITS'(quantum_ff);
            if (ge_ff) begin
               st_wr.epoch_we  = 1'b1;
               st_wr.epoch_val = alu_sum;
               st_wr.bytes_we  = 1'b1;
               st_wr.bytes_val = limit_ff;
               budget_in       = limit_ff;
            end else begin
               budget_in       = rd_bytes;
            end
            state_in = ST_FIT;
         end
         // fit check and deduct in one subtract
         ST_FIT: begin
            alu_op = ALU_SUB;
            alu_a  = TIME_BITS'(budget_ff);
            alu_b  = TIME_BITS'(item_ff.packet_length);
            if (alu_carry) begin
               st_wr.bytes_we       = 1'b1;
               st_wr.bytes_val      = alu_sum[BUDGET_W-1:0];
               pend_in.admitted     = 1'b1;
               pend_in.granted_band = 3'(band_ff);
               pend_in.budget_left  = alu_sum[BUDGET_W-1:0];
               state_in             = ST_DONE;
            end else begin
               pend_in.admitted     = 1'b0;
               pend_in.granted_band = 3'(band_ff);
               pend_in.budget_left  = budget_ff;
               if (downgrade_ff && (band_ff != '0)) begin
                  band_in  = next_band;
                  state_in = ST_EPOCH;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         // hand the result over once the output register is free
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      band_ff   <= band_in;
      ge_ff     <= ge_in;
      limit_ff  <= limit_in;
      budget_ff <= budget_in;
      pend_ff   <= pend_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/bebac_alu.sv
// bebac_alu: the single shared adder/subtractor of the admission core.
// Used for the epoch compare, the epoch end sum and the budget fit/deduct.
// Depends on bebac_pkg.
module bebac_alu (
   input  bebac_pkg::alu_op_type             op,
   input  logic [bebac_pkg::TIME_BITS-1:0]   a,
   input  logic [bebac_pkg::TIME_BITS-1:0]   b,
   output logic [bebac_pkg::TIME_BITS-1:0]   sum,
   output logic                              carry
);
   import bebac_pkg::*;

   logic [TIME_BITS-1:0] b_eff;
   logic [TIME_BITS:0]   full;

   // subtract as a + ~b + 1; carry out set means no borrow (a >= b)
   always_comb begin
      b_eff = (op == ALU_SUB) ? ~b : b;
      full  = {1'b0, a} + {1'b0, b_eff} + (TIME_BITS + 1)'(op == ALU_SUB);
   end

   assign sum   = full[TIME_BITS-1:0];
   assign carry = full[TIME_BITS];

endmodule

FILE: rtl/bebac_store.sv
// bebac_store: per-band byte budget and epoch end registers.
// One read and one write band per cycle; everything clears to zero on reset.
// Depends on bebac_pkg.
module bebac_store (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [bebac_pkg::BAND_W-1:0]      band,
   input  bebac_pkg::store_wr_type           wr,
   output logic [bebac_pkg::BUDGET_W-1:0]    rd_bytes,
   output logic [bebac_pkg::TIME_BITS-1:0]   rd_epoch
);
   import bebac_pkg::*;

   logic [BAND_SLOTS-1:0][BUDGET_W-1:0]  bytes_ff;
   logic [BAND_SLOTS-1:0][TIME_BITS-1:0] epoch_ff;

   // zero epoch end means the first arrival in a band refills it
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff <= '0;
         epoch_ff <= '0;
      end else begin
         if (wr.bytes_we) begin
            bytes_ff[band] <= wr.bytes_val;
         end
         if (wr.epoch_we) begin
            epoch_ff[band] <= wr.epoch_val;
         end
      end
   end

   assign rd_bytes = bytes_ff[band];
   assign rd_epoch = epoch_ff[band];

endmodule

FILE: tb/tb_band_epoch_budget_admission_core.sv
// Testbench for band_epoch_budget_admission_core: directed and random packet
// arrivals, checked beat by beat against a per-band budget predictor.
// Depends on bebac_pkg and the core RTL only.
module tb_band_epoch_budget_admission_core;
   import bebac_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int TAIL_CYCLES = 30;
   localparam int REPORT_MAX  = 10;

   // Clock and block ports
   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   // Predictor copy of the registers
   logic [QUANT_W-1:0] quantum_m     = QUANTUM_RST;
   logic [UNIT_W-1:0]  unit_m        = UNIT_RST;
   logic [MULTS_W-1:0] mults_low_m   = MULTS_LOW_RST;
   logic [MULTS_W-1:0] mults_high_m  = MULTS_HIGH_RST;
   logic [COUNT_W-1:0] band_count_m  = BAND_COUNT_RST;
   logic               downgrade_m   = 1'b0;

   // Predictor copy of the band stores, cleared at time zero to match the reset
   logic [BUDGET_W-1:0]  budget_m    [BAND_SLOTS];
   logic [TIME_BITS-1:0] epoch_end_m [BAND_SLOTS];

   rsp_type        expected_verdicts[$];
   int unsigned    mismatch_count = 0;
   int unsigned    quiet_cycles   = 0;
   int unsigned    req_idle_pct   = 0;
   int unsigned    rsp_idle_pct   = 0;
   int unsigned    hold_request   = 0;
   int unsigned    hold_left      = 0;
   logic [NOW_W-1:0] stamp_now    = '0;

   band_epoch_budget_admission_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      for (int b = 0; b < BAND_SLOTS; b++) begin
         budget_m[b]    = '0;
         epoch_end_m[b] = '0;
      end
   end

   // ---------------------------------------------------------------------
   // Budget predictor
   // ---------------------------------------------------------------------

   // Byte limit of a band: its 16-bit multiplier times the unit
   function automatic logic [BUDGET_W-1:0] band_limit_m(int unsigned band);
      logic [MULTS_W-1:0] word;
      logic [MULT_W-1:0]  mult;
      if (band >= 8) return '0;
      word = (band < 4) ? mults_low_m : mults_high_m;
      mult = word[(band % 4) * MULT_W +: MULT_W];
      return BUDGET_W'(mult) * BUDGET_W'(unit_m);
   endfunction

   // One try on a band: refill when its epoch has run out, then charge
   function automatic bit charge_band(int unsigned band, logic [LEN_W-1:0] len,
                                      logic [TIME_BITS-1:0] now);
      if (now >= epoch_end_m[band]) begin
         epoch_end_m[band] = now + TIME_BITS'(quantum_m);
         budget_m[band]    = band_limit_m(band);
      end
      if (BUDGET_W'(len) <= budget_m[band]) begin
         budget_m[band] = budget_m[band] - BUDGET_W'(len);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Admission verdict for one arrival, walking the downgrade chain if enabled
   function automatic rsp_type predict_verdict(req_type pkt);
      int unsigned bands;
      int unsigned band;
      bit          ok;
      rsp_type     verdict;
      bands = band_count_m;
      if (bands == 0) bands = 1;
      if (bands > BAND_SLOTS) bands = BAND_SLOTS;
      band = pkt.priority_req;
      if (band >= bands) band = bands - 1;
      ok = charge_band(band, pkt.packet_length, pkt.now_cycles);
      // band 3 drops straight to band 0, the others step down by one
      while (!ok && downgrade_m && band != 0) begin
         band = (band == 3) ? 0 : band - 1;
         ok = charge_band(band, pkt.packet_length, pkt.now_cycles);
      end
      verdict.admitted     = ok;
      verdict.granted_band = band[2:0];
      verdict.budget_left  = budget_m[band];
      return verdict;
   endfunction

   // Register write as the block sees it, masked to each register's width
   function automatic void apply_register(logic [CSR_IDX_W-1:0] idx,
                                          logic [CSR_DAT_W-1:0] value);
      case (idx)
         CSR_QUANTUM:    quantum_m    = value[QUANT_W-1:0];
         CSR_UNIT:       unit_m       = value[UNIT_W-1:0];
         CSR_MULTS_LOW:  mults_low_m  = value[MULTS_W-1:0];
         CSR_MULTS_HIGH: mults_high_m = value[MULTS_W-1:0];
         CSR_BAND_COUNT: band_count_m = value[COUNT_W-1:0];
         CSR_DOWNGRADE:  downgrade_m  = value[0];
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Result checker, receiver stalls and watchdog
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            if (mismatch_count < REPORT_MAX)
               $display("unexpected result beat: admitted %0d band %0d budget %0d",
                        rsp_data.admitted, rsp_data.granted_band, rsp_data.budget_left);
            mismatch_count++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_data.admitted !== want.admitted ||
                rsp_data.granted_band !== want.granted_band ||
                rsp_data.budget_left !== want.budget_left) begin
               if (mismatch_count < REPORT_MAX)
                  $display("verdict mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                           want.admitted, want.granted_band, want.budget_left,
                           rsp_data.admitted, rsp_data.granted_band,
                           rsp_data.budget_left);
               mismatch_count++;
            end
         end
      end
   end

   // Receiver: long hold-off when asked, else random stalls
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // Watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Shared drivers
   // ---------------------------------------------------------------------

   // Offer one arrival and record its verdict once the beat is taken
   task automatic send_packet(input logic [LEN_W-1:0] len, input logic [PRIO_W-1:0] prio,
                              input logic [NOW_W-1:0] now);
      req_type pkt;
      pkt.packet_length = len;
      pkt.priority_req  = prio;
      pkt.now_cycles    = now;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= pkt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_verdicts.push_back(predict_verdict(pkt));
   endtask

   // Stop offering and wait for every outstanding verdict
   task automatic settle_block();
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_register(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Four multiplier lanes, mostly small so budgets run out often
   function automatic logic [MULTS_W-1:0] pick_multipliers();
      logic [MULTS_W-1:0] word;
      if ($urandom_range(19) == 0) return {$urandom, $urandom};
      for (int lane = 0; lane < 4; lane++)
         word[lane * MULT_W +: MULT_W] = ($urandom_range(9) == 0) ?
            MULT_W'($urandom_range(65535)) : MULT_W'($urandom_range(12));
      return word;
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset values: zero-multiplier band, clamp of the priority, length extremes
   task automatic test_reset_defaults();
      send_packet(16'd0,     8'd1,   64'd0);
      send_packet(16'd1,     8'd1,   64'd1);
      send_packet(16'hFFFF,  8'd0,   64'd2);
      send_packet(16'd200,   8'd255, 64'd3);
      send_packet(16'd128,   8'd7,   64'd4);
      send_packet(16'd0,     8'd3,   64'd5);
      stamp_now = 64'd6;
   endtask

   // Downgrade chain 7..4, 3 to 0; the first packet refills every band it tries
   task automatic test_downgrade_chain();
      settle_block();
      write_reg(CSR_QUANTUM,    64'd1000);
      write_reg(CSR_UNIT,       64'd100);
      write_reg(CSR_MULTS_LOW,  {16'd2, 16'd1, 16'd3, 16'd4});
      write_reg(CSR_MULTS_HIGH, {16'd1, 16'd1, 16'd1, 16'd1});
      write_reg(CSR_DOWNGRADE,  64'd1);
      stamp_now = 64'd200000;
      send_packet(16'd350, 8'd7, stamp_now);
      send_packet(16'd350, 8'd2, stamp_now + 1);
      send_packet(16'd401, 8'd0, stamp_now + 2);
      send_packet(16'd0,   8'd3, stamp_now + 3);
      stamp_now = stamp_now + 4;
   endtask

   // Widest budget, quantum zero, saturated and zero band counts, unit zero,
   // with write data carrying bits above each register's width
   task automatic test_register_extremes();
      settle_block();
      write_reg(CSR_QUANTUM,    64'hFFFF_FFFF_0000_0000);
      write_reg(CSR_UNIT,       64'hABCD_0000_0000_FFFF);
      write_reg(CSR_MULTS_LOW,  64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CSR_BAND_COUNT, 64'h0F0F);
      write_reg(CSR_DOWNGRADE,  64'h2);
      send_packet(16'hFFFF, 8'd0, stamp_now);
      send_packet(16'd1,    8'd0, stamp_now);
      send_packet(16'hFFFF, 8'd9, stamp_now + 1);
      settle_block();
      write_reg(CSR_BAND_COUNT, 64'h10);
      send_packet(16'd100, 8'd255, stamp_now + 2);
      settle_block();
      write_reg(CSR_UNIT, 64'd0);
      send_packet(16'd0, 8'd0, stamp_now + 3);
      send_packet(16'd1, 8'd0, stamp_now + 4);
      stamp_now = stamp_now + 5;
   endtask

   // Epoch end wrapping past the top of the timestamp range
   task automatic test_epoch_wrap();
      settle_block();
      write_reg(CSR_QUANTUM,    64'hFFFF_FFFF);
      write_reg(CSR_UNIT,       64'd1);
      write_reg(CSR_MULTS_HIGH, {16'd16, 16'd16, 16'd16, 16'd16});
      write_reg(CSR_BAND_COUNT, 64'd8);
      send_packet(16'd5, 8'd4, 64'hFFFF_FFFF_FFFF_FFF0);
      send_packet(16'd3, 8'd4, 64'hFFFF_FFFF_FFFF_FFFF);
      send_packet(16'd3, 8'd5, 64'h0);
      stamp_now = 64'd1000;
   endtask

   // New random register set, written while the block is idle
   task automatic shuffle_config();
      logic [QUANT_W-1:0] quantum;
      logic [UNIT_W-1:0]  unit;
      settle_block();
      case ($urandom_range(9))
         0:       quantum = '0;
         1:       quantum = '1;
         2:       quantum = 32'd1;
         default: quantum = QUANT_W'($urandom_range(400, 20));
      endcase
      case ($urandom_range(9))
         0:       unit = '0;
         1:       unit = '1;
         default: unit = UNIT_W'($urandom_range(200, 1));
      endcase
      write_reg(CSR_QUANTUM,    {$urandom, quantum});
      write_reg(CSR_UNIT,       CSR_DAT_W'({$urandom, $urandom_range(65535), unit}));
      write_reg(CSR_MULTS_LOW,  pick_multipliers());
      write_reg(CSR_MULTS_HIGH, pick_multipliers());
      write_reg(CSR_BAND_COUNT,
                ($urandom_range(1) == 0) ? 64'd8 : CSR_DAT_W'($urandom_range(15)));
      write_reg(CSR_DOWNGRADE,  CSR_DAT_W'($urandom_range(3)));
   endtask

   // Mostly ordered arrivals near the budget scale, some raw noise
   task automatic test_random_traffic(input int unsigned sender_pct,
                                      input int unsigned receiver_pct,
                                      input int unsigned items);
      logic [LEN_W-1:0]  len;
      logic [PRIO_W-1:0] prio;
      int unsigned       roll;
      req_idle_pct = sender_pct;
      rsp_idle_pct = receiver_pct;
      for (int n = 0; n < items; n++) begin
         if (n % 36 == 0) shuffle_config();
         roll = $urandom_range(99);
         if (roll < 10) begin
            len       = LEN_W'($urandom);
            prio      = PRIO_W'($urandom);
            stamp_now = {$urandom, $urandom};
         end else begin
            if (roll < 75)
               stamp_now = stamp_now + NOW_W'($urandom_range(30));
            else
               stamp_now = stamp_now + NOW_W'(quantum_m) + NOW_W'($urandom_range(5));
            len  = LEN_W'($urandom_range(32'(unit_m) * 2 + 4));
            prio = ($urandom_range(7) == 0) ? PRIO_W'($urandom_range(15))
                                            : PRIO_W'($urandom_range(7));
         end
         send_packet(len, prio, stamp_now);
      end
   endtask

   // Receiver holds off for a long stretch while arrivals keep coming
   task automatic test_output_backpressure();
      settle_block();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_request = 400;
      for (int n = 0; n < 30; n++) begin
         stamp_now = stamp_now + NOW_W'($urandom_range(40));
         send_packet(LEN_W'($urandom_range(32'(unit_m) + 2)), PRIO_W'($urandom_range(7)),
                     stamp_now);
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      req_idle_pct = 22;
      rsp_idle_pct = 86;
      test_reset_defaults();
      test_downgrade_chain();
      test_register_extremes();
      test_epoch_wrap();
      test_random_traffic(22, 86, 200);
      test_random_traffic(86, 22, 200);
      test_output_backpressure();
      test_random_traffic(0, 0, 200);
      settle_block();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
